FILE: src/pbls_pkg.sv
`timescale 1ns / 1ps

package pbls_pkg;

    // opcodes of a request item
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_SHED    = 2'd1;
    localparam logic [1:0] OP_RECHECK = 2'd2;

    localparam int LOAD_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int NUM_W    = 7;
    localparam int LEVEL_W  = 24;
    // demand - supply, signed
    localparam int MARGIN_W = LEVEL_W + 1;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [5:0]                entry_index;
        logic signed [LOAD_W-1:0]  entry_power;
        logic [LEVEL_W-1:0]        supply;
        logic [LEVEL_W-1:0]        demand;
    } req_item_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] unserved_load;
        logic [NUM_W-1:0]          unserved_entries;
        logic [NUM_W-1:0]          changed_entries;
    } rsp_item_t;

    // outcome of visiting one table entry during a walk
    typedef struct packed {
        logic               flip;
        logic               flag_next;
        logic [TOTAL_W-1:0] unserved_next;
        logic               stop;
    } step_t;

endpackage

FILE: src/pbls_ram.sv
`timescale 1ns / 1ps

module pbls_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/pbls_eval.sv
`timescale 1ns / 1ps

module pbls_eval (
    input  logic [1:0]                             opcode,
    input  logic                                   flag,
    input  logic signed [pbls_pkg::LOAD_W-1:0]     load,
    input  logic [pbls_pkg::TOTAL_W-1:0]           unserved,
    input  logic signed [pbls_pkg::MARGIN_W-1:0]   margin,
    output pbls_pkg::step_t                        step
);

    localparam int TW = pbls_pkg::TOTAL_W;

    logic signed [TW-1:0] load_ext;
    logic signed [TW-1:0] margin_ext;
    logic signed [TW:0]   margin_wide;
    logic signed [TW:0]   diff_wide;
    logic [TW-1:0]        sum;
    logic                 fits;

    always_comb
    begin
        load_ext    = TW'(load);
        margin_ext  = TW'(margin);
        margin_wide = (TW + 1)'(margin);
        sum         = unserved + load_ext;
        // unserved - load without wrap; fits when it still covers demand - supply
        diff_wide   = $signed({unserved[TW-1], unserved}) - (TW + 1)'(load);
        fits        = diff_wide >= margin_wide;

        step.flip          = 1'b0;
        step.flag_next     = flag;
        step.unserved_next = unserved;
        step.stop          = 1'b0;

        if (opcode == pbls_pkg::OP_SHED)
        begin
            step.flip          = !flag && (load > 0);
            step.flag_next     = 1'b1;
            step.unserved_next = sum;
            step.stop          = $signed(sum) >= margin_ext;
        end
        else if (opcode == pbls_pkg::OP_RECHECK)
        begin
            step.flip          = flag && fits;
            step.flag_next     = 1'b0;
            step.unserved_next = diff_wide[TW-1:0];
            step.stop          = $signed(diff_wide[TW-1:0]) == margin_ext;
        end
    end

endmodule

FILE: src/power_budget_load_shedder.sv
`timescale 1ns / 1ps

// Load shedder over a table of consumers.
// req channel (req_valid / req_stall / req): one item per opcode. A write item
// stores an entry's load; a shed item blacks out powered entries in index order
// until demand - unserved <= supply; a recheck item restores blacked-out entries
// that fit, stopping when served load meets supply exactly. Opcode 3 reports only.
// rsp channel (rsp_valid / rsp_stall / rsp): one item per request with the
// unserved total, unserved count and the number of entries switched.
// cfg_wr_en / cfg_wr_data set entry_count (saturated to MAX_ENTRIES at walk start).
// Timing: a write or report item goes from ST_DONE into the output register. A walk
// reads one entry per cycle from the load and flag memories and writes the flag
// back in the same cycle; it visits entries up to the walk length, then its result
// goes from ST_DONE into the output register. The next item is taken in the cycle
// the result appears. One item is in work at a time.
// Reset: the flag memory is cleared one entry a cycle, all MAX_ENTRIES entries, with
// req_stall high; config writes are taken meanwhile. Loads are undefined until
// written. A stalled result waits in the output register; the next item is
// accepted and worked on, and holds before delivery until that register frees.
module power_budget_load_shedder #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                req_valid,
    output logic                req_stall,
    input  pbls_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output pbls_pkg::rsp_item_t rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int TW    = pbls_pkg::TOTAL_W;
    localparam int NW    = pbls_pkg::NUM_W;
    localparam int MW    = pbls_pkg::MARGIN_W;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK, ST_DONE} state_t;

    state_t                  state_reg,           state_next;
    logic [IDX_W-1:0]        clr_idx_reg,         clr_idx_next;
    logic [IDX_W-1:0]        eval_idx_reg,        eval_idx_next;
    logic [CNT_W-1:0]        walk_len_reg,        walk_len_next;
    logic [6:0]              entry_count_reg,     entry_count_next;
    logic [1:0]              op_reg,              op_next;
    logic signed [MW-1:0]    margin_reg,          margin_next;
    logic [TW-1:0]           unserved_total_reg,  unserved_total_next;
    logic [NW-1:0]           unserved_number_reg, unserved_number_next;
    logic [NW-1:0]           changed_reg,         changed_next;
    logic                    rsp_valid_reg,       rsp_valid_next;
    pbls_pkg::rsp_item_t     rsp_reg,             rsp_next;

    logic [CNT_W-1:0]        walk_len_sat;
    logic                    walk_last;
    logic [IDX_W-1:0]        rd_addr;
    logic                    load_we;
    logic [IDX_W-1:0]        load_waddr;
    logic signed [pbls_pkg::LOAD_W-1:0] load_rdata;
    logic                    flag_we;
    logic [IDX_W-1:0]        flag_waddr;
    logic                    flag_wdata;
    logic                    flag_rdata;
    pbls_pkg::step_t         step;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign walk_len_sat = (32'(entry_count_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                                : CNT_W'(entry_count_reg);
    assign walk_last    = (CNT_W'(eval_idx_reg) + CNT_W'(1)) == walk_len_reg;
    // the next entry is read while the current one is evaluated
    assign rd_addr      = (state_reg == ST_WALK) ? eval_idx_reg + IDX_W'(1) : '0;
    assign load_waddr   = IDX_W'(req.entry_index);

    pbls_ram #(
        .WIDTH  (pbls_pkg::LOAD_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_load_ram (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (load_waddr),
        .wr_data (req.entry_power),
        .rd_addr (rd_addr),
        .rd_data (load_rdata)
    );

    pbls_ram #(
        .WIDTH  (1),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_flag_ram (
        .clk     (clk),
        .wr_en   (flag_we),
        .wr_addr (flag_waddr),
        .wr_data (flag_wdata),
        .rd_addr (rd_addr),
        .rd_data (flag_rdata)
    );

    pbls_eval u_eval (
        .opcode   (op_reg),
        .flag     (flag_rdata),
        .load     (load_rdata),
        .unserved (unserved_total_reg),
        .margin   (margin_reg),
        .step     (step)
    );

    always_comb
    begin
        state_next           = state_reg;
        clr_idx_next         = clr_idx_reg;
        eval_idx_next        = eval_idx_reg;
        walk_len_next        = walk_len_reg;
        entry_count_next     = entry_count_reg;
        op_next              = op_reg;
        margin_next          = margin_reg;
        unserved_total_next  = unserved_total_reg;
        unserved_number_next = unserved_number_reg;
        changed_next         = changed_reg;
        rsp_valid_next       = rsp_valid_reg;
        rsp_next             = rsp_reg;
        load_we              = 1'b0;
        flag_we              = 1'b0;
        flag_waddr           = eval_idx_reg;
        flag_wdata           = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            entry_count_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                flag_we    = 1'b1;
                flag_waddr = clr_idx_reg;
                if (32'(clr_idx_reg) == MAX_ENTRIES - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req.opcode;
                    margin_next   = $signed({1'b0, req.demand}) - $signed({1'b0, req.supply});
                    changed_next  = '0;
                    walk_len_next = walk_len_sat;
                    eval_idx_next = '0;
                    if (req.opcode == pbls_pkg::OP_WRITE)
                    begin
                        load_we    = 32'(req.entry_index) < MAX_ENTRIES;
                        state_next = ST_DONE;
                    end
                    else if ((req.opcode == pbls_pkg::OP_SHED ||
                              req.opcode == pbls_pkg::OP_RECHECK) && walk_len_sat != '0)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                if (step.flip)
                begin
                    flag_we             = 1'b1;
                    flag_wdata          = step.flag_next;
                    unserved_total_next = step.unserved_next;
                    changed_next        = changed_reg + NW'(1);
                    if (op_reg == pbls_pkg::OP_SHED)
                    begin
                        unserved_number_next = unserved_number_reg + NW'(1);
                    end
                    else
                    begin
                        unserved_number_next = unserved_number_reg - NW'(1);
                    end
                end
                if ((step.flip && step.stop) || walk_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    eval_idx_next = eval_idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next                = 1'b1;
                    rsp_next.unserved_load        = unserved_total_reg;
                    rsp_next.unserved_entries     = unserved_number_reg;
                    rsp_next.changed_entries      = changed_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_CLEAR;
            clr_idx_reg         <= '0;
            eval_idx_reg        <= '0;
            walk_len_reg        <= '0;
            entry_count_reg     <= '0;
            op_reg              <= '0;
            margin_reg          <= '0;
            unserved_total_reg  <= '0;
            unserved_number_reg <= '0;
            changed_reg         <= '0;
            rsp_valid_reg       <= 1'b0;
            rsp_reg             <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            clr_idx_reg         <= clr_idx_next;
            eval_idx_reg        <= eval_idx_next;
            walk_len_reg        <= walk_len_next;
            entry_count_reg     <= entry_count_next;
            op_reg              <= op_next;
            margin_reg          <= margin_next;
            unserved_total_reg  <= unserved_total_next;
            unserved_number_reg <= unserved_number_next;
            changed_reg         <= changed_next;
            rsp_valid_reg       <= rsp_valid_next;
            rsp_reg             <= rsp_next;
        end
    end

    // walk never visits past the saturated entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> CNT_W'(eval_idx_reg) < walk_len_reg)
        else $error("walk index beyond walk length");

    // blackout totals only move while walking
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_WALK |=> $stable(unserved_number_reg) && $stable(unserved_total_reg))
        else $error("unserved totals changed outside a walk");

    // flag memory is written only by the clearing pass or a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        flag_we |-> (state_reg == ST_CLEAR || state_reg == ST_WALK))
        else $error("flag memory written while idle");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item accepted before the first completed");

    // a walk cannot end with more switches than entries visited
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> 32'(changed_reg) <= 32'(eval_idx_reg))
        else $error("changed count exceeds visited entries");

endmodule
